>>> sv/acr_pkg.sv
package acr_pkg;

  // default receive store depth
  localparam int unsigned RX_DEPTH = 256;

  // transaction kinds
  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  // bus register map
  localparam logic [3:0] REG_TX_COUNT = 4'd0;
  localparam logic [3:0] REG_RX_COUNT = 4'd1;
  localparam logic [3:0] REG_CONFIG   = 4'd2;
  localparam logic [3:0] REG_STATUS   = 4'd3;
  localparam logic [3:0] REG_DATA     = 4'd4;

  // receive error codes
  localparam logic [1:0] RX_ERR_NONE     = 2'd0;
  localparam logic [1:0] RX_ERR_SPURIOUS = 2'd1;
  localparam logic [1:0] RX_ERR_FULL     = 2'd2;

  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [31:0] write_mask;
    logic [7:0]  rx_sample;
    logic        tx_pending;
    logic        rx_pending;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        unmapped;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        config_valid;
    logic [31:0] config_value;
    logic        tx_mode;
    logic        rx_mode;
    logic        rx_underflow;
    logic [1:0]  rx_error;
  } out_t;

endpackage

>>> sv/acr_chan_if.sv
interface acr_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/acr_ram.sv
module acr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/audio_codec_register_block.sv
// Audio codec register block. Each input transaction is a bus read, a bus write or an
// arriving receive sample, and yields exactly one result transaction. A new transaction is
// taken every cycle unless the output stalls; its result passes the receive store read
// (synchronous memory) and the output register. Counters, config and pointers
// sit in flops and are updated at accept, so back-to-back transactions see each other's
// effects at once. The receive store is a RxDepth-entry byte memory tracked by read and
// write pointers and a fill count; a change of receive mode empties it by resetting those,
// so no clearing pass is needed after reset.
module audio_codec_register_block #(
  parameter int unsigned RxDepth = acr_pkg::RX_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  acr_chan_if.sink   in_i,
  acr_chan_if.source out_o
);
  import acr_pkg::*;

  localparam int unsigned PtrW  = (RxDepth > 1) ? $clog2(RxDepth) : 1;
  localparam int unsigned FillW = $clog2(RxDepth + 1);

  // architectural state
  logic [31:0]      tx_cnt_q, tx_cnt_d;
  logic [31:0]      rx_cnt_q, rx_cnt_d;
  logic [31:0]      cfg_q, cfg_d;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             tx_mode_q, tx_mode_d;
  logic             rx_mode_q, rx_mode_d;

  // pipeline
  logic s1_valid_q, s2_valid_q;
  out_t s1_q, s2_q, s2_d, res;
  logic s1_pop_q;
  logic s1_move, in_fire;
  logic pop, push, bus;
  logic [7:0] ram_rdata;
  in_t  req;

  assign req     = in_i.payload;
  assign s1_move = !s2_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_fire = in_i.valid && in_i.ready;

  function automatic logic [31:0] merge(logic [31:0] old, logic [31:0] data,
                                        logic [31:0] mask);
    return (old & ~mask) | (data & mask);
  endfunction

  // next state and result of the incoming transaction
  always_comb begin
    tx_cnt_d  = tx_cnt_q;
    rx_cnt_d  = rx_cnt_q;
    cfg_d     = cfg_q;
    wr_ptr_d  = wr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    fill_d    = fill_q;
    tx_mode_d = tx_mode_q;
    rx_mode_d = rx_mode_q;
    res       = '0;
    pop       = 1'b0;
    push      = 1'b0;
    bus       = 1'b0;

    case (req.mode)
      MODE_READ: begin
        bus = 1'b1;
        unique case (req.reg_index)
          REG_TX_COUNT: res.read_data = tx_cnt_q;
          REG_RX_COUNT: res.read_data = rx_cnt_q;
          REG_CONFIG:   res.read_data = cfg_q;
          REG_STATUS: begin
            res.read_data = {7'd0, tx_cnt_q != 32'd0,
                             7'd0, (rx_cnt_q != 32'd0) && (fill_q != '0),
                             7'd0, req.tx_pending,
                             7'd0, req.rx_pending};
          end
          REG_DATA: begin
            if (rx_cnt_q != 32'd0) begin
              if (fill_q == '0) begin
                res.rx_underflow = 1'b1;
              end else begin
                // byte is placed in read_data after the memory read
                pop      = 1'b1;
                rd_ptr_d = (rd_ptr_q == PtrW'(RxDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
                fill_d   = fill_q - 1'b1;
              end
              rx_cnt_d = rx_cnt_q - 32'd1;
            end
          end
          default: res.unmapped = 1'b1;
        endcase
      end
      MODE_WRITE: begin
        bus = 1'b1;
        unique case (req.reg_index)
          REG_TX_COUNT: tx_cnt_d = merge(tx_cnt_q, req.write_data, req.write_mask);
          REG_RX_COUNT: rx_cnt_d = merge(rx_cnt_q, req.write_data, req.write_mask);
          REG_CONFIG: begin
            cfg_d            = merge(cfg_q, req.write_data, req.write_mask);
            res.config_valid = 1'b1;
          end
          REG_STATUS: ;
          REG_DATA: begin
            if (tx_cnt_q != 32'd0) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = req.write_data[31:24] & BYTE_MASK;
              tx_cnt_d     = tx_cnt_q - 32'd1;
            end
          end
          default: res.unmapped = 1'b1;
        endcase
      end
      MODE_SAMPLE: begin
        if (rx_cnt_q == 32'd0) begin
          res.rx_error = RX_ERR_SPURIOUS;
        end else if (fill_q == FillW'(RxDepth)) begin
          res.rx_error = RX_ERR_FULL;
        end else begin
          push     = 1'b1;
          wr_ptr_d = (wr_ptr_q == PtrW'(RxDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
          fill_d   = fill_q + 1'b1;
        end
      end
      default: ;
    endcase

    // mode flags follow the counts after bus accesses; a receive mode change empties the store
    if (bus) begin
      tx_mode_d = tx_cnt_d != 32'd0;
      if ((rx_cnt_d != 32'd0) != rx_mode_q) begin
        rx_mode_d = !rx_mode_q;
        wr_ptr_d  = '0;
        rd_ptr_d  = '0;
        fill_d    = '0;
      end
    end

    res.config_value = cfg_d;
    res.tx_mode      = tx_mode_d;
    res.rx_mode      = rx_mode_d;
  end

  // state update on accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_cnt_q  <= '0;
      rx_cnt_q  <= '0;
      cfg_q     <= '0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      fill_q    <= '0;
      tx_mode_q <= 1'b0;
      rx_mode_q <= 1'b0;
    end else if (in_fire) begin
      tx_cnt_q  <= tx_cnt_d;
      rx_cnt_q  <= rx_cnt_d;
      cfg_q     <= cfg_d;
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      fill_q    <= fill_d;
      tx_mode_q <= tx_mode_d;
      rx_mode_q <= rx_mode_d;
    end
  end

  // receive sample store
  acr_ram #(
    .Width (8),
    .Depth (RxDepth)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && push),
    .waddr_i (wr_ptr_q),
    .wdata_i (req.rx_sample),
    .re_i    (in_fire && pop),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_fire;
      end
      if (s1_move) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // popped byte merged into the result
  always_comb begin
    s2_d = s1_q;
    if (s1_pop_q) begin
      s2_d.read_data = {ram_rdata, 24'd0};
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q     <= res;
      s1_pop_q <= pop;
    end
    if (s1_move && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_o.valid   = s2_valid_q;
  assign out_o.payload = s2_q;

endmodule
